// ----- rtl/core/aef_pkg.sv -----
// Shared types, constants and codes of the adaptive EMA ADC filter.
`default_nettype none

package aef_pkg;

   // Fixed field and register widths.
   localparam int DATA_BITS      = 16;
   localparam int FRAC_BITS      = 16;
   localparam int ALPHA_BITS     = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Default sample width in counts.
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Alpha selection constants.
   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 16'd32768;
   localparam logic [DATA_BITS-1:0]  BIG_ERROR = 16'd35;
   localparam int ALPHA_SHIFT = 15;

   // Interpolation divide: 16-bit weight span times an error offset below 34,
   // divided by seven times a band below 34.
   localparam int OFFSET_BITS  = 6;
   localparam int DIV_NUM_BITS = ALPHA_BITS + OFFSET_BITS;
   localparam int DIV_DEN_BITS = 8;

   // Register reset values.
   localparam logic [DATA_BITS-1:0]  BAND_RESET      = 16'd4;
   localparam logic [ALPHA_BITS-1:0] WEIGHT_LO_RESET = 16'd1024;
   localparam logic [ALPHA_BITS-1:0] WEIGHT_HI_RESET = 16'd32768;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_LO = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_HI = 2'd2;

   // Request types.
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_RESEED = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERROR,
      ST_PICK,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // Divider control and status.
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Sequencer outputs to the datapath.
   typedef struct packed {
      logic req_ready;
      logic capture;
      logic seed_load;
      logic error_load;
      logic alpha_fixed_load;
      logic div_start;
      logic alpha_div_load;
      logic mul_load;
      logic upd_load;
      logic rsp_load;
   } seq_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/aef_ifs.sv -----
// Request and response channel interfaces of the adaptive EMA ADC filter.
`default_nettype none

interface aef_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [aef_pkg::DATA_BITS-1:0]  sample;

   modport source (output valid, output req_type, output sample, input ready);
   modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface aef_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [aef_pkg::DATA_BITS-1:0]  filtered;

   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/aef_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module aef_divider #(
   parameter int NUM_BITS = aef_pkg::DIV_NUM_BITS,
   parameter int DEN_BITS = aef_pkg::DIV_DEN_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire aef_pkg::div_ctrl_type ctrl,
   input  wire logic [NUM_BITS-1:0]  dividend,
   input  wire logic [DEN_BITS-1:0]  divisor,
   output aef_pkg::div_stat_type     stat,
   output logic      [NUM_BITS-1:0]  quotient
);
   import aef_pkg::*;

   localparam int CNT_BITS = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(NUM_BITS - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;

   logic [DEN_BITS:0]   partial;
   logic [DEN_BITS:0]   trial;
   logic                fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      partial = {rem_ff, quo_ff[NUM_BITS-1]};
      trial   = partial - {1'b0, den_ff};
      fits    = partial >= {1'b0, den_ff};
   end

   // Next values of the iteration registers.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[NUM_BITS-2:0], fits};
         rem_in   = fits ? trial[DEN_BITS-1:0] : partial[DEN_BITS-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers take reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Working registers need no reset.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   // A new divide is only started when the unit is free.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !busy_ff)
      else $error("divider started while busy");

   // Completion follows the last step and clears busy.
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctrl.start && count_ff == LAST_STEP) |=> (done_ff && !busy_ff))
      else $error("divider did not complete after its last step");

   // Done and busy never show together.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

`default_nettype wire

// ----- rtl/core/adaptive_ema_adc_filter.sv -----
// Adaptive exponential moving average filter for ADC samples (top level).
//
// Requests arrive on req_if (valid/ready): req_type 0 filters the sample into
// the Q16.16 level, req_type 1 reseeds the level to the sample. Each request
// yields exactly one response on rsp_if carrying the integer part of the level.
// Only the low SAMPLE_BITS bits of a sample are used.
// One request is worked on at a time; req_if.ready is high only when the
// sequencer is idle. A reseed, or the first update after reset, goes from
// ST_ERROR straight to ST_DONE. An update with a fixed weight passes through
// ST_PICK, ST_MULTIPLY and ST_UPDATE; one whose weight is interpolated inside
// the adaptive band also waits in ST_DIVIDE for the 22-step restoring divider.
// The response sits in an output register, so the next request is accepted
// while a response still waits; a finished request holds in the sequencer
// until that register is free, so a stalled receiver loses nothing.
// Reset (synchronous, active high) clears the level and the seeded flag and
// loads the register defaults: band 4, low weight 1024, high weight 32768.
// Registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while idle, which the block does not enforce; index 3 is ignored.
`default_nettype none

module adaptive_ema_adc_filter #(
   parameter int SAMPLE_BITS = aef_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   aef_req_if.sink                                  req_if,
   aef_rsp_if.source                                rsp_if,
   input  wire logic                                csr_we,
   input  wire logic [aef_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [aef_pkg::DATA_BITS-1:0]       csr_wdata
);
   import aef_pkg::*;

   localparam int LEVEL_BITS = SAMPLE_BITS + FRAC_BITS;
   localparam int PROD_BITS  = ALPHA_BITS + LEVEL_BITS;
   localparam int STEP_BITS  = PROD_BITS + 1 - ALPHA_SHIFT;
   localparam int NEXT_BITS  = STEP_BITS + 2;
   localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = {{SAMPLE_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
   localparam logic [PROD_BITS:0]    ROUND_UP  = (PROD_BITS + 1)'((1 << ALPHA_SHIFT) - 1);

   // Configuration registers.
   logic [DATA_BITS-1:0]  band_ff;
   logic [ALPHA_BITS-1:0] amin_ff;
   logic [ALPHA_BITS-1:0] amax_ff;

   // Sequencer.
   state_type    state_ff, state_in;
   seq_ctrl_type ctrl;

   // Filter state and working registers.
   logic [LEVEL_BITS-1:0]  level_ff, level_in;
   logic                   seeded_ff;
   logic                   type_ff;
   logic [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0] error_ff;
   logic [ALPHA_BITS-1:0]  alpha_ff, alpha_in;
   logic [PROD_BITS-1:0]   prod_ff;
   logic                   up_ff;
   logic [DATA_BITS-1:0]   result_ff, result_in;

   // Response register.
   logic                   rsp_valid_ff;
   logic [DATA_BITS-1:0]   rsp_data_ff;

   // Divider connection.
   div_ctrl_type              div_ctrl;
   div_stat_type              div_stat;
   logic [DIV_NUM_BITS-1:0]   div_num;
   logic [DIV_DEN_BITS-1:0]   div_den;
   logic [DIV_NUM_BITS-1:0]   div_quo;

   // Combinational datapath signals.
   logic                   take_seed;
   logic [SAMPLE_BITS-1:0] y_int;
   logic [SAMPLE_BITS-1:0] abs_err;
   logic [DATA_BITS-1:0]   err16;
   logic [DATA_BITS+2:0]   band_hi;
   logic                   interp;
   logic [ALPHA_BITS-1:0]  alpha_fixed;
   logic [ALPHA_BITS-1:0]  weight_span;
   logic [DATA_BITS-1:0]   err_off_w;
   logic [OFFSET_BITS-1:0] err_off;
   logic [OFFSET_BITS-1:0] band6;
   logic [OFFSET_BITS+2:0] span_w;
   logic [DIV_NUM_BITS-1:0] interp_prod;
   logic [LEVEL_BITS-1:0]  x_q16;
   logic                   up_dir;
   logic [LEVEL_BITS-1:0]  level_gap;
   logic [PROD_BITS-1:0]   prod_in;
   logic [PROD_BITS:0]     rounded;
   logic [STEP_BITS-1:0]   step;
   logic signed [NEXT_BITS-1:0] next_level;
   logic [LEVEL_BITS-1:0]  level_upd;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= BAND_RESET;
         amin_ff <= WEIGHT_LO_RESET;
         amax_ff <= WEIGHT_HI_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BAND:      band_ff <= csr_wdata;
            CSR_WEIGHT_LO: amin_ff <= csr_wdata;
            CSR_WEIGHT_HI: amax_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Error between the sample and the integer part of the level.
   always_comb begin
      take_seed = (type_ff == REQ_RESEED) || !seeded_ff;
      y_int     = level_ff[LEVEL_BITS-1:FRAC_BITS];
      abs_err   = (x_ff >= y_int) ? (x_ff - y_int) : (y_int - x_ff);
   end

   // Weight selection in priority order; the interpolated case goes to the divider.
   always_comb begin
      err16   = DATA_BITS'(error_ff);
      band_hi = {band_ff, 3'b000};
      interp  = 1'b0;
      if (amax_ff < amin_ff) begin
         alpha_fixed = amin_ff;
      end else if (band_ff == '0) begin
         alpha_fixed = amax_ff;
      end else if (err16 <= band_ff) begin
         alpha_fixed = amin_ff;
      end else if (err16 >= BIG_ERROR) begin
         alpha_fixed = ALPHA_ONE;
      end else if ({3'b000, err16} >= band_hi) begin
         alpha_fixed = amax_ff;
      end else begin
         alpha_fixed = amin_ff;
         interp      = 1'b1;
      end
   end

   // Interpolation operands: band and error offset are both below 34 here.
   always_comb begin
      weight_span = amax_ff - amin_ff;
      err_off_w   = err16 - band_ff;
      err_off     = err_off_w[OFFSET_BITS-1:0];
      band6       = band_ff[OFFSET_BITS-1:0];
      span_w      = {band6, 3'b000} - (OFFSET_BITS + 3)'(band6);
      div_den     = span_w[DIV_DEN_BITS-1:0];
      interp_prod = DIV_NUM_BITS'(weight_span) * DIV_NUM_BITS'(err_off);
      div_num     = interp_prod + DIV_NUM_BITS'(div_den[DIV_DEN_BITS-1:1]);
   end

   // Weighted step toward the sample.
   always_comb begin
      x_q16     = {x_ff, {FRAC_BITS{1'b0}}};
      up_dir    = x_q16 >= level_ff;
      level_gap = up_dir ? (x_q16 - level_ff) : (level_ff - x_q16);
      prod_in   = PROD_BITS'(alpha_ff) * PROD_BITS'(level_gap);
   end

   // Shift with floor toward minus infinity, then clamp to the level range.
   always_comb begin
      rounded = up_ff ? (PROD_BITS + 1)'(prod_ff)
                      : (PROD_BITS + 1)'(prod_ff) + ROUND_UP;
      step    = rounded[PROD_BITS:ALPHA_SHIFT];
      if (up_ff) begin
         next_level = signed'(NEXT_BITS'(level_ff)) + signed'(NEXT_BITS'(step));
      end else begin
         next_level = signed'(NEXT_BITS'(level_ff)) - signed'(NEXT_BITS'(step));
      end
      if (next_level < 0) begin
         level_upd = '0;
      end else if (next_level > signed'(NEXT_BITS'(LEVEL_TOP))) begin
         level_upd = LEVEL_TOP;
      end else begin
         level_upd = next_level[LEVEL_BITS-1:0];
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_if.valid) state_in = ST_ERROR;
         ST_ERROR:    state_in = take_seed ? ST_DONE : ST_PICK;
         ST_PICK:     state_in = interp ? ST_DIVIDE : ST_MULTIPLY;
         ST_DIVIDE:   if (div_stat.done) state_in = ST_MULTIPLY;
         ST_MULTIPLY: state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_DONE;
         ST_DONE:     if (!rsp_valid_ff || rsp_if.ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.capture   = req_if.valid;
         end
         ST_ERROR: begin
            ctrl.seed_load  = take_seed;
            ctrl.error_load = !take_seed;
         end
         ST_PICK: begin
            ctrl.div_start        = interp;
            ctrl.alpha_fixed_load = !interp;
         end
         ST_DIVIDE:   ctrl.alpha_div_load = div_stat.done;
         ST_MULTIPLY: ctrl.mul_load = 1'b1;
         ST_UPDATE:   ctrl.upd_load = 1'b1;
         ST_DONE:     ctrl.rsp_load = !rsp_valid_ff || rsp_if.ready;
         default: begin
         end
      endcase
   end

   assign req_if.ready   = ctrl.req_ready;
   assign div_ctrl.start = ctrl.div_start;

   // Next level, weight and result.
   always_comb begin
      level_in  = level_ff;
      alpha_in  = alpha_ff;
      result_in = result_ff;
      if (ctrl.seed_load) begin
         level_in  = x_q16;
         result_in = DATA_BITS'(x_ff);
      end
      if (ctrl.upd_load) begin
         level_in  = level_upd;
         result_in = DATA_BITS'(level_upd[LEVEL_BITS-1:FRAC_BITS]);
      end
      if (ctrl.alpha_fixed_load) begin
         alpha_in = alpha_fixed;
      end
      if (ctrl.alpha_div_load) begin
         alpha_in = amin_ff + div_quo[ALPHA_BITS-1:0];
      end
   end

   // Control and filter state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         if (ctrl.seed_load) begin
            seeded_ff <= 1'b1;
         end
         if (ctrl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         type_ff <= req_if.req_type;
         x_ff    <= req_if.sample[SAMPLE_BITS-1:0];
      end
      if (ctrl.error_load) begin
         error_ff <= abs_err;
      end
      if (ctrl.mul_load) begin
         prod_ff <= prod_in;
         up_ff   <= up_dir;
      end
      if (ctrl.rsp_load) begin
         rsp_data_ff <= result_ff;
      end
      alpha_ff  <= alpha_in;
      result_ff <= result_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.filtered = rsp_data_ff;

   // Iterative divider for the interpolated weight.
   aef_divider #(
      .NUM_BITS(DIV_NUM_BITS),
      .DEN_BITS(DIV_DEN_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_num),
      .divisor  (div_den),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Once a request is taken, no other is taken in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("second request accepted while busy");

   // The level never leaves its clamped range.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_TOP)
      else $error("level above the clamp limit");

   // A finished request waits while the response register is full and stalled.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_if.ready) |=> state_ff == ST_DONE)
      else $error("finished request left while the response was stalled");

   // Every response follows a seeding of the level.
   a_rsp_seeded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> seeded_ff)
      else $error("response produced before the level was seeded");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench of the adaptive EMA ADC filter: level predictor, stimulus and checks.
`timescale 1ns / 100ps

module tb_top;
   import aef_pkg::*;

   localparam int CLOCK_PERIOD     = 20;
   localparam int PHASE_COUNT      = 12;
   localparam int RANDOM_PER_PHASE = 120;
   localparam int PRESSURE_PHASE   = 8;
   localparam int LONG_HOLD_CYCLES = 300;

   // Index that decodes to no register; writes to it must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam logic [DATA_BITS-1:0] SAMPLE_TOP = '1;
   localparam longint LEVEL_TOP = ((longint'(1) << DATA_BITS) - 1) << FRAC_BITS;

   // Register settings per phase; the first row matches the reset values.
   localparam logic [DATA_BITS-1:0] BAND_SET [PHASE_COUNT] =
      '{4, 0, 1, 34, 7, 65535, 3, 5, 33, 4, 2, 20};
   localparam logic [DATA_BITS-1:0] LO_SET [PHASE_COUNT] =
      '{1024, 1024, 0, 0, 2000, 500, 32768, 0, 65535, 1024, 16384, 100};
   localparam logic [DATA_BITS-1:0] HI_SET [PHASE_COUNT] =
      '{32768, 65535, 32768, 65535, 30000, 32768, 100, 0, 65535, 32768, 40000, 50000};

   // Predicts the filtered level for each accepted request and checks responses in order.
   class ema_scoreboard;
      bit [DATA_BITS-1:0] band_cfg;
      bit [DATA_BITS-1:0] weight_lo;
      bit [DATA_BITS-1:0] weight_hi;
      bit [31:0]          level_fx;
      bit                 primed;
      bit [DATA_BITS-1:0] expected_filtered[$];
      int errors, requests, reseeds, responses, interpolated, clamped;

      function new();
         band_cfg  = BAND_RESET;
         weight_lo = WEIGHT_LO_RESET;
         weight_hi = WEIGHT_HI_RESET;
         level_fx  = '0;
         primed    = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [DATA_BITS-1:0] value);
         case (index)
            CSR_BAND:      band_cfg = value;
            CSR_WEIGHT_LO: weight_lo = value;
            CSR_WEIGHT_HI: weight_hi = value;
            default: ;
         endcase
      endfunction

      // Q15 weight from the absolute error, in the same priority as the hardware.
      function bit [ALPHA_BITS-1:0] choose_weight(bit [DATA_BITS-1:0] err);
         bit [31:0] span;
         bit [31:0] frac;
         if (weight_hi < weight_lo) return weight_lo;
         if (band_cfg == 0) return weight_hi;
         if (err <= band_cfg) return weight_lo;
         if (err >= BIG_ERROR) return ALPHA_ONE;
         if (32'(err) >= 32'(band_cfg) * 8) return weight_hi;
         span = 32'(band_cfg) * 7;
         frac = (32'(weight_hi - weight_lo) * 32'(err - band_cfg) + span / 2) / span;
         interpolated++;
         return ALPHA_BITS'(32'(weight_lo) + frac);
      endfunction

      function void note_request(logic kind, logic [DATA_BITS-1:0] sample);
         bit [DATA_BITS-1:0]  cur;
         bit [DATA_BITS-1:0]  err;
         bit [ALPHA_BITS-1:0] w;
         bit [63:0]           target;
         bit [63:0]           mag;
         bit [63:0]           delta;
         longint              nxt;
         requests++;
         if (kind == REQ_RESEED || !primed) begin
            // A reseed, or the first update after reset, loads the sample directly.
            if (kind == REQ_RESEED) reseeds++;
            level_fx = {sample, 16'd0};
            primed = 1'b1;
         end else begin
            cur = level_fx[31:16];
            err = (sample >= cur) ? sample - cur : cur - sample;
            w = choose_weight(err);
            target = 64'(sample) << FRAC_BITS;
            // Moving down rounds the step up, so the shift acts as a floor.
            if (target >= 64'(level_fx)) begin
               mag = 64'(w) * (target - 64'(level_fx));
               delta = mag >> ALPHA_SHIFT;
               nxt = longint'(64'(level_fx)) + longint'(delta);
            end else begin
               mag = 64'(w) * (64'(level_fx) - target);
               delta = (mag + 64'h7FFF) >> ALPHA_SHIFT;
               nxt = longint'(64'(level_fx)) - longint'(delta);
            end
            if (nxt < 0) begin
               level_fx = '0;
               clamped++;
            end else if (nxt > LEVEL_TOP) begin
               level_fx = 32'(LEVEL_TOP);
               clamped++;
            end else begin
               level_fx = 32'(nxt);
            end
         end
         expected_filtered.push_back(level_fx[31:16]);
      endfunction

      function void check_response(logic [DATA_BITS-1:0] got);
         bit [DATA_BITS-1:0] want;
         responses++;
         if (expected_filtered.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %0d", $time, got);
         end else begin
            want = expected_filtered.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: filtered mismatch, expected %0d, actual %0d", $time, want, got);
            end
         end
      endfunction

      function int pending();
         return expected_filtered.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [DATA_BITS-1:0]      csr_wdata;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles    = 0;
   ema_scoreboard sb;

   aef_req_if req_ch();
   aef_rsp_if rsp_ch();

   adaptive_ema_adc_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Response side: random stalls, and one long hold-off counted down here.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Both handshakes are observed at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.req_type, req_ch.sample);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.filtered);
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [DATA_BITS-1:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(index, value);
   endtask

   // Lets every outstanding request finish, then a few quiet cycles.
   task automatic settle();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Offers one request from a falling edge and returns at the falling edge after acceptance.
   task automatic send_request(input logic kind, input logic [DATA_BITS-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.req_type = kind;
      req_ch.sample = value;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Mostly updates close to the current level, so that the adaptive band is exercised.
   task automatic send_random();
      int pick;
      int offset;
      logic [DATA_BITS-1:0] cur;
      logic [DATA_BITS-1:0] value;
      pick = $urandom_range(99);
      offset = $urandom_range(40);
      cur = sb.level_fx[31:16];
      if (pick < 6) begin
         send_request(REQ_RESEED, DATA_BITS'($urandom));
      end else if (pick < 16) begin
         send_request(REQ_UPDATE, DATA_BITS'($urandom));
      end else if (pick < 20) begin
         value = $urandom_range(1) ? SAMPLE_TOP : '0;
         send_request(REQ_UPDATE, value);
      end else begin
         if ($urandom_range(1))
            value = (int'(cur) + offset > int'(SAMPLE_TOP)) ? SAMPLE_TOP
                                                             : DATA_BITS'(int'(cur) + offset);
         else
            value = (int'(cur) < offset) ? '0 : DATA_BITS'(int'(cur) - offset);
         send_request(REQ_UPDATE, value);
      end
   endtask

   // Main sequence: reset, then one phase per register setting.
   initial begin
      sb = new();
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_UPDATE;
      req_ch.sample = '0;
      csr_we = 1'b0;
      csr_index = CSR_BAND;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         settle();
         if (ph > 0) begin
            write_csr(CSR_BAND, BAND_SET[ph]);
            write_csr(CSR_WEIGHT_LO, LO_SET[ph]);
            write_csr(CSR_WEIGHT_HI, HI_SET[ph]);
         end
         if (ph == PRESSURE_PHASE) write_csr(CSR_UNUSED, '1);

         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase

         // Directed openers: unseeded update, each weight region, rails and reseeds.
         if (ph == 0) begin
            send_request(REQ_UPDATE, 16'h1234);
            send_request(REQ_UPDATE, 16'h1236);
            send_request(REQ_UPDATE, 16'h123A);
            send_request(REQ_UPDATE, 16'h1242);
            send_request(REQ_UPDATE, 16'h1270);
            send_request(REQ_RESEED, 16'h0000);
            send_request(REQ_UPDATE, SAMPLE_TOP);
            send_request(REQ_RESEED, SAMPLE_TOP);
            send_request(REQ_UPDATE, 16'h0000);
            send_request(REQ_RESEED, 16'h8000);
            send_request(REQ_UPDATE, 16'h8005);
            send_request(REQ_UPDATE, 16'h8020);
            send_request(REQ_UPDATE, 16'h7FF0);
            send_request(REQ_RESEED, 16'hAAAA);
            send_request(REQ_UPDATE, 16'h5555);
            send_request(REQ_RESEED, 16'h5555);
            send_request(REQ_UPDATE, 16'h5557);
         end else if (ph == 1) begin
            // Weights above one overshoot and are held by the clamp at both ends.
            send_request(REQ_RESEED, 16'd10);
            send_request(REQ_UPDATE, 16'd0);
            send_request(REQ_RESEED, 16'd65530);
            send_request(REQ_UPDATE, SAMPLE_TOP);
         end

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (ph == PRESSURE_PHASE && n == 30) hold_cycles = LONG_HOLD_CYCLES;
            if (ph == PRESSURE_PHASE && n == 80) settle();
            send_random();
         end
      end

      settle();
      $display("Run covered %0d requests (%0d reseeds) over %0d register settings",
               sb.requests, sb.reseeds, PHASE_COUNT);
      $display("and four idling patterns; checked %0d responses, %0d interpolated weights,",
               sb.responses, sb.interpolated);
      $display("%0d clamped levels, %0d errors.", sb.clamped, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/aef_pkg.sv
rtl/core/aef_ifs.sv
rtl/core/aef_divider.sv
rtl/core/adaptive_ema_adc_filter.sv
sim/tb_top.sv
